// ===== sv/interval_usage_timer_bank_assert.svh =====
// Assertion macros shared by the usage timer bank RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef INTERVAL_USAGE_TIMER_BANK_ASSERT_SVH
`define INTERVAL_USAGE_TIMER_BANK_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Check a property on every rising clock edge outside reset.
`define IVUT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds on a rising clock edge outside reset.
`define IVUT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define IVUT_ASSERT(label, clk, rst_n, prop, msg)
`define IVUT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

// ===== sv/ivut_pkg.sv =====
// Package for the usage timer bank: sizes, payload structs, codes and
// controller/datapath command and status types. Depends on nothing.
package ivut_pkg;

    localparam int ITEM_COUNT = 16;
    localparam int IDX_W      = (ITEM_COUNT > 1) ? $clog2(ITEM_COUNT) : 1;

    typedef enum logic [1:0] {
        MODE_START  = 2'd0,
        MODE_STOP   = 2'd1,
        MODE_CLEAR  = 2'd2,
        MODE_REPORT = 2'd3
    } mode_t;

    typedef enum logic {
        ST_IDLE,
        ST_REPORT
    } state_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  item_index;
        logic [31:0] time_now;
    } req_t;

    typedef struct packed {
        logic [5:0]  item_number;
        logic [31:0] total_time;
        logic        last;
    } rpt_t;

    typedef struct packed {
        logic             ev_start;
        logic             ev_stop;
        logic             ev_clear;
        logic             load_expiry;
        logic             rep_step;
        logic             rep_last;
        logic [IDX_W-1:0] rep_idx;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

endpackage

// ===== sv/ivut_datapath.sv =====
// Datapath of the usage timer bank: per-item stamps, totals, running marks,
// the fold adder and the result register. Depends on ivut_pkg.
module ivut_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  ivut_pkg::req_t      req,
    input  ivut_pkg::dp_cmd_t   cmd,
    output ivut_pkg::dp_status_t status,
    output logic                rpt_valid,
    output ivut_pkg::rpt_t      rpt,
    input  logic                rpt_stall
);

    logic [31:0]                   stamp_reg [ivut_pkg::ITEM_COUNT];
    logic [31:0]                   acc_reg   [ivut_pkg::ITEM_COUNT];
    logic [ivut_pkg::ITEM_COUNT-1:0] run_reg;
    logic [31:0]                   expiry_reg;
    logic                          rpt_valid_reg;
    ivut_pkg::rpt_t                rpt_reg;

    logic                      idx_ok;
    logic [ivut_pkg::IDX_W-1:0] addr;
    logic [31:0]               t_sel;
    logic [31:0]               rd_stamp;
    logic [31:0]               rd_acc;
    logic                      rd_run;
    logic [31:0]               acc_next;

    assign idx_ok   = {1'b0, req.item_index} < 9'(ivut_pkg::ITEM_COUNT);
    assign addr     = cmd.rep_step ? cmd.rep_idx : req.item_index[ivut_pkg::IDX_W-1:0];
    assign t_sel    = cmd.rep_step ? expiry_reg : req.time_now;
    assign rd_stamp = stamp_reg[addr];
    assign rd_acc   = acc_reg[addr];
    assign rd_run   = run_reg[addr];
    // Fold the elapsed time into the total, wrapping modulo 2^32.
    assign acc_next = rd_acc + (t_sel - rd_stamp);

    assign status.out_free = !rpt_valid_reg || !rpt_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ivut_pkg::ITEM_COUNT; i++)
            begin
                stamp_reg[i] <= '0;
                acc_reg[i]   <= '0;
            end
            run_reg <= '0;
        end
        else
        begin
            if (cmd.ev_clear)
            begin
                for (int i = 0; i < ivut_pkg::ITEM_COUNT; i++)
                begin
                    acc_reg[i] <= '0;
                end
            end
            if (cmd.ev_start && idx_ok)
            begin
                stamp_reg[addr] <= t_sel;
                run_reg[addr]   <= 1'b1;
            end
            if (cmd.ev_stop && idx_ok && rd_run)
            begin
                acc_reg[addr] <= acc_next;
                run_reg[addr] <= 1'b0;
            end
            if (cmd.rep_step && rd_run)
            begin
                acc_reg[addr]   <= acc_next;
                stamp_reg[addr] <= t_sel;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_expiry)
        begin
            expiry_reg <= req.time_now;
        end
        if (cmd.rep_step)
        begin
            rpt_reg.item_number <= 6'(cmd.rep_idx);
            rpt_reg.total_time  <= rd_run ? acc_next : rd_acc;
            rpt_reg.last        <= cmd.rep_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rpt_valid_reg <= 1'b0;
        end
        else if (cmd.rep_step)
        begin
            rpt_valid_reg <= 1'b1;
        end
        else if (!rpt_stall)
        begin
            rpt_valid_reg <= 1'b0;
        end
    end

    assign rpt_valid = rpt_valid_reg;
    assign rpt       = rpt_reg;

endmodule

// ===== sv/ivut_ctrl.sv =====
// Controller of the usage timer bank: accepts requests, issues event strobes
// and walks the items during a report run. Depends on ivut_pkg and the
// assertion header.
`include "interval_usage_timer_bank_assert.svh"

module ivut_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    input  logic [1:0]           mode,
    output logic                 req_stall,
    input  ivut_pkg::dp_status_t status,
    output ivut_pkg::dp_cmd_t    cmd
);

    ivut_pkg::state_t           state_reg, state_next;
    logic [ivut_pkg::IDX_W-1:0] cnt_reg, cnt_next;
    logic                       accept;
    logic                       last_item;

    assign last_item = cnt_reg == ivut_pkg::IDX_W'(ivut_pkg::ITEM_COUNT - 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ivut_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        req_stall       = 1'b1;
        accept          = 1'b0;
        cmd             = '0;
        cmd.rep_idx     = cnt_reg;
        cmd.rep_last    = last_item;
        case (state_reg)
            ivut_pkg::ST_IDLE:
            begin
                req_stall = 1'b0;
                accept    = req_valid;
                cmd.ev_start    = accept && (mode == ivut_pkg::MODE_START);
                cmd.ev_stop     = accept && (mode == ivut_pkg::MODE_STOP);
                cmd.ev_clear    = accept && (mode == ivut_pkg::MODE_CLEAR);
                cmd.load_expiry = accept && (mode == ivut_pkg::MODE_REPORT);
                if (cmd.load_expiry)
                begin
                    cnt_next   = '0;
                    state_next = ivut_pkg::ST_REPORT;
                end
            end
            ivut_pkg::ST_REPORT:
            begin
                // Advance one item each time the result register can take it.
                cmd.rep_step = status.out_free;
                if (status.out_free)
                begin
                    cnt_next = ivut_pkg::IDX_W'(cnt_reg + 1'b1);
                    if (last_item)
                    begin
                        cnt_next   = '0;
                        state_next = ivut_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ivut_pkg::ST_IDLE;
            end
        endcase
    end

    `IVUT_ASSERT(a_stall_in_report, clk, rst_n, (state_reg == ivut_pkg::ST_REPORT) |-> req_stall, "request accepted during report run")
    `IVUT_ASSERT(a_last_ends_run, clk, rst_n, (cmd.rep_step && cmd.rep_last) |=> (state_reg == ivut_pkg::ST_IDLE), "report run did not end after last item")
    `IVUT_NEVER(a_step_outside_run, clk, rst_n, cmd.rep_step && (state_reg != ivut_pkg::ST_REPORT), "report step outside report run")
    `IVUT_ASSERT(a_run_starts_at_zero, clk, rst_n, cmd.load_expiry |=> (cnt_reg == '0), "report walk not starting at item zero")

endmodule

// ===== sv/interval_usage_timer_bank.sv =====
// Top level of the usage timer bank: joins controller and datapath.
// Depends on ivut_pkg, ivut_ctrl and ivut_datapath.
//
// Usage:
//   Requests arrive on req (mode, item_index, time_now) with req_valid and
//   req_stall; a transfer happens at a clock edge with valid high and stall
//   low. Start, stop and new-interval requests give no result, so they can
//   be sent back to back.
//   A report request walks all ITEM_COUNT items in index order, one per
//   cycle while the result register is free: each running item has its time
//   up to the given expiry folded into its total and its stamp moved to the
//   expiry. Every total leaves on rpt (item_number, total_time, last) with
//   rpt_valid and rpt_stall; last marks the final item. The first result is
//   registered after the controller enters its report state, and req_stall
//   stays high for the whole run.
//   The walk is set by the single read/fold port on the item tables.
//   A stalled result holds in the output register; the walk waits for it.
//   Reset (rst_n low, asynchronous) clears every stamp, total and running
//   mark and drops rpt_valid.
module interval_usage_timer_bank (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  ivut_pkg::req_t req,
    output logic           rpt_valid,
    input  logic           rpt_stall,
    output ivut_pkg::rpt_t rpt
);

    // Command strobes from the controller, free-slot status back from the
    // datapath.
    ivut_pkg::dp_cmd_t    cmd;
    ivut_pkg::dp_status_t status;

    ivut_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .mode      (req.mode),
        .req_stall (req_stall),
        .status    (status),
        .cmd       (cmd)
    );

    ivut_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .status    (status),
        .rpt_valid (rpt_valid),
        .rpt       (rpt),
        .rpt_stall (rpt_stall)
    );

endmodule
